@@ hdl/ofrb_pkg.sv @@
// Shared types, codes and defaults for the overlapping frame ring buffer.
package ofrb_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 65536;
    localparam int unsigned MAX_FRAME_DEF    = 512;

    typedef logic [1:0] t_req;
    localparam t_req REQ_WRITE = 2'd0;
    localparam t_req REQ_READ  = 2'd1;
    localparam t_req REQ_CLEAR = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_WRITE_DONE = 2'd0;
    localparam t_kind KIND_FRAME_WORD = 2'd1;
    localparam t_kind KIND_UNDERRUN   = 2'd2;
    localparam t_kind KIND_CLEARED    = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_LEN = 2'd0;
    localparam t_cfg_idx CFG_HOP       = 2'd1;
    localparam t_cfg_idx CFG_READY     = 2'd2;

    localparam logic [9:0]  FRAME_LEN_RST = 10'd512;
    localparam logic [9:0]  HOP_RST       = 10'd512;
    localparam logic [16:0] READY_RST     = 17'd1024;

    // Byte lane where a frame word starts and how many bytes it carries.
    typedef struct packed {
        logic [2:0] lane;
        logic [3:0] cnt;
    } t_word_sel;

endpackage

@@ hdl/ofrb_store.sv @@
// Byte store split into even and odd 8-byte rows, one unaligned word read per cycle.
module ofrb_store #(
    parameter int unsigned BUFFER_BYTES = ofrb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [$clog2(BUFFER_BYTES)-1:0] i_wr_addr,
    input  logic [7:0]                      i_wr_data,
    input  logic                            i_rd_en,
    input  logic [$clog2(BUFFER_BYTES)-1:0] i_rd_pos,
    output logic [63:0]                     o_rd_lo,
    output logic [63:0]                     o_rd_hi
);
    import ofrb_pkg::*;

    localparam int unsigned AW        = $clog2(BUFFER_BYTES);
    localparam int unsigned HALF_ROWS = BUFFER_BYTES / 16;
    localparam int unsigned HW        = AW - 4;

    logic [63:0] r_mem_even [HALF_ROWS];
    logic [63:0] r_mem_odd  [HALF_ROWS];

    logic [63:0]   r_even_q;
    logic [63:0]   r_odd_q;
    logic          r_start_odd;
    logic [HW-1:0] w_rd_half;
    logic [HW-1:0] w_even_idx;
    logic [HW-1:0] w_wr_half;
    logic [5:0]    w_wr_base;

    assign w_rd_half = i_rd_pos[AW-1:4];
    assign w_wr_half = i_wr_addr[AW-1:4];
    assign w_wr_base = {i_wr_addr[2:0], 3'b000};

    // A word starting in an odd row spills into the next even row; wrap at the end.
    always_comb begin
        if (i_rd_pos[3]) begin
            if (w_rd_half == HW'(HALF_ROWS - 1)) begin
                w_even_idx = '0;
            end else begin
                w_even_idx = w_rd_half + HW'(1);
            end
        end else begin
            w_even_idx = w_rd_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_addr[3]) begin
                r_mem_odd[w_wr_half][w_wr_base +: 8] <= i_wr_data;
            end else begin
                r_mem_even[w_wr_half][w_wr_base +: 8] <= i_wr_data;
            end
        end
        if (i_rd_en) begin
            r_even_q    <= r_mem_even[w_even_idx];
            r_odd_q     <= r_mem_odd[w_rd_half];
            r_start_odd <= i_rd_pos[3];
        end
    end

    assign o_rd_lo = r_start_odd ? r_odd_q : r_even_q;
    assign o_rd_hi = r_start_odd ? r_even_q : r_odd_q;

endmodule

@@ hdl/ofrb_align.sv @@
// Byte rotate and tail mask that turn two stored rows into one frame word.
module ofrb_align (
    input  logic                 [63:0] i_lo,
    input  logic                 [63:0] i_hi,
    input  ofrb_pkg::t_word_sel         i_sel,
    output logic                 [63:0] o_word
);
    import ofrb_pkg::*;

    logic [127:0] w_pair;
    logic [127:0] w_shifted;

    assign w_pair    = {i_hi, i_lo};
    assign w_shifted = w_pair >> {i_sel.lane, 3'b000};

    // Zero the bytes past the end of the frame.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < i_sel.cnt) begin
                o_word[b*8 +: 8] = w_shifted[b*8 +: 8];
            end else begin
                o_word[b*8 +: 8] = 8'h00;
            end
        end
    end

endmodule

@@ hdl/overlapping_frame_ring_buffer_core.sv @@
// Top level of the overlapping frame ring buffer: request control, pointers and result port.
//
//   channel   signals                                     transfer at rising edge when
//   --------  ------------------------------------------  ----------------------------
//   request   start, busy, i_req_type, i_data_byte         start && !busy
//   result    o_strobe, o_result_kind, o_data_word, ...    o_strobe (one cycle, no stall)
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index/data   i_cfg_valid && o_cfg_ready
//
// Write, clear and underrun requests show their result on the cycle after the
// transfer, and a new request may follow every cycle.
// A frame read gives ceil(len/8) words, one per cycle; each word passes from the issue
// stage through the registered row memory reads into the result register. Busy stays
// high until the last word strobes.
// Reset (synchronous, active low) clears pointers and fill count and returns the
// configuration to its defaults; the byte store is not cleared. The receiver cannot
// stall results.
// BUFFER_BYTES must be a multiple of 16 (rows of 8 bytes in an even/odd pair).
module overlapping_frame_ring_buffer_core #(
    parameter int unsigned BUFFER_BYTES    = ofrb_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned MAX_FRAME_BYTES = ofrb_pkg::MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ofrb_pkg::t_req     i_req_type,
    input  logic [7:0]         i_data_byte,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  ofrb_pkg::t_cfg_idx i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    output logic               o_strobe,
    output ofrb_pkg::t_kind    o_result_kind,
    output logic [63:0]        o_data_word,
    output logic [3:0]         o_byte_count,
    output logic               o_last,
    output logic               o_frame_ready,
    output logic               o_overflow
);
    import ofrb_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned LW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CW = (FW > 17) ? FW : 17;
    localparam int unsigned PW = AW + 1;

    // Configuration registers.
    logic [9:0]  r_cfg_len;
    logic [9:0]  r_cfg_hop;
    logic [16:0] r_cfg_ready;

    // Ring state.
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [FW-1:0] r_fill;

    // Frame read sequencer: issue stage, then memory stage.
    logic          r_busy;
    logic          r_issue;
    logic [AW-1:0] r_pos;
    logic [LW-1:0] r_left;
    logic          r_s1_valid;
    t_word_sel     r_s1_sel;
    logic          r_s1_last;
    logic          r_burst_ready;

    // Result register.
    logic          r_strobe;
    logic          n_strobe;
    t_kind         r_kind;
    logic [63:0]   r_word;
    logic [3:0]    r_cnt;
    logic          r_last;
    logic          r_ready;
    logic          r_ovf;

    logic          w_accept;
    logic          w_wr_en;
    logic [LW-1:0] w_len;
    logic          w_underrun;
    logic [FW-1:0] w_hop_ext;
    logic [FW-1:0] w_fill_rd;
    logic [FW-1:0] w_fill_wr;
    logic          w_full;
    logic [PW-1:0] w_rp_sum;
    logic [AW-1:0] w_rp_next;
    logic [AW-1:0] w_wp_next;
    logic [PW-1:0] w_pos_sum;
    logic [AW-1:0] w_pos_next;
    logic [3:0]    w_issue_cnt;
    logic          w_issue_last;
    logic [63:0]   w_rd_lo;
    logic [63:0]   w_rd_hi;
    logic [63:0]   w_aligned;

    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_wr_en     = w_accept && (i_req_type == REQ_WRITE);

    // Clamp the frame length into 1..MAX_FRAME_BYTES.
    always_comb begin
        if (r_cfg_len == '0) begin
            w_len = LW'(1);
        end else if (r_cfg_len > 10'(MAX_FRAME_BYTES)) begin
            w_len = LW'(MAX_FRAME_BYTES);
        end else begin
            w_len = r_cfg_len[LW-1:0];
        end
    end

    assign w_underrun = r_fill < FW'(w_len);

    // Advance the read side by the hop; floor the count at zero.
    assign w_hop_ext = FW'(r_cfg_hop);
    assign w_fill_rd = (w_hop_ext > r_fill) ? '0 : r_fill - w_hop_ext;
    assign w_rp_sum  = {1'b0, r_rp} + PW'(r_cfg_hop);
    assign w_rp_next = (w_rp_sum >= PW'(BUFFER_BYTES)) ?
                       AW'(w_rp_sum - PW'(BUFFER_BYTES)) : AW'(w_rp_sum);

    // Write side: saturate the count at the store size, flag the overwrite.
    assign w_full    = r_fill == FW'(BUFFER_BYTES);
    assign w_fill_wr = w_full ? r_fill : r_fill + FW'(1);
    assign w_wp_next = (r_wp == AW'(BUFFER_BYTES - 1)) ? '0 : r_wp + AW'(1);

    // Issue one 8-byte word per cycle from the frame position.
    assign w_issue_last = r_left <= LW'(8);
    assign w_issue_cnt  = w_issue_last ? 4'(r_left) : 4'd8;
    assign w_pos_sum    = {1'b0, r_pos} + PW'(8);
    assign w_pos_next   = (w_pos_sum >= PW'(BUFFER_BYTES)) ?
                          AW'(w_pos_sum - PW'(BUFFER_BYTES)) : AW'(w_pos_sum);

    // Strobe writes, clears and underruns at once, and every frame word as it lands.
    always_comb begin
        n_strobe = r_s1_valid;
        if (w_accept) begin
            if (i_req_type inside {REQ_WRITE, REQ_CLEAR}) begin
                n_strobe = 1'b1;
            end else if (i_req_type == REQ_READ && w_underrun) begin
                n_strobe = 1'b1;
            end
        end
    end

    function automatic logic ready_at(input logic [FW-1:0] fill, input logic [16:0] thr);
        return CW'(fill) >= CW'(thr);
    endfunction

    ofrb_store #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (i_data_byte),
        .i_rd_en   (r_issue),
        .i_rd_pos  (r_pos),
        .o_rd_lo   (w_rd_lo),
        .o_rd_hi   (w_rd_hi)
    );

    ofrb_align u_align (
        .i_lo   (w_rd_lo),
        .i_hi   (w_rd_hi),
        .i_sel  (r_s1_sel),
        .o_word (w_aligned)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= FRAME_LEN_RST;
            r_cfg_hop   <= HOP_RST;
            r_cfg_ready <= READY_RST;
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_issue     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FRAME_LEN: r_cfg_len   <= i_cfg_data[9:0];
                    CFG_HOP:       r_cfg_hop   <= i_cfg_data[9:0];
                    CFG_READY:     r_cfg_ready <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            r_strobe <= n_strobe;
            if (w_accept) begin
                case (i_req_type)
                    REQ_WRITE: begin
                        r_wp   <= w_wp_next;
                        r_fill <= w_fill_wr;
                    end
                    REQ_READ: begin
                        // Underrun answers at once and leaves the ring alone.
                        if (!w_underrun) begin
                            r_busy  <= 1'b1;
                            r_issue <= 1'b1;
                            r_rp    <= w_rp_next;
                            r_fill  <= w_fill_rd;
                        end
                    end
                    REQ_CLEAR: begin
                        r_wp   <= '0;
                        r_rp   <= '0;
                        r_fill <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_issue && w_issue_last) begin
                r_issue <= 1'b0;
            end
            r_s1_valid <= r_issue;

            // Drop busy as the last frame word moves into the result register.
            if (r_s1_valid && r_s1_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos         <= r_rp;
            r_left        <= w_len;
            r_burst_ready <= ready_at(w_fill_rd, r_cfg_ready);
            r_word        <= '0;
            r_cnt         <= '0;
            r_last        <= 1'b1;
            case (i_req_type)
                REQ_WRITE: begin
                    r_kind  <= KIND_WRITE_DONE;
                    r_ready <= ready_at(w_fill_wr, r_cfg_ready);
                    r_ovf   <= w_full;
                end
                REQ_READ: begin
                    r_kind  <= KIND_UNDERRUN;
                    r_ready <= ready_at(r_fill, r_cfg_ready);
                    r_ovf   <= 1'b0;
                end
                REQ_CLEAR: begin
                    r_kind  <= KIND_CLEARED;
                    r_ready <= ready_at('0, r_cfg_ready);
                    r_ovf   <= 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (r_issue) begin
            r_pos          <= w_pos_next;
            r_left         <= r_left - LW'(8);
            r_s1_sel.lane  <= r_pos[2:0];
            r_s1_sel.cnt   <= w_issue_cnt;
            r_s1_last      <= w_issue_last;
        end

        if (r_s1_valid) begin
            r_kind  <= KIND_FRAME_WORD;
            r_word  <= w_aligned;
            r_cnt   <= r_s1_sel.cnt;
            r_last  <= r_s1_last;
            r_ready <= r_burst_ready;
            r_ovf   <= 1'b0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_data_word   = r_word;
    assign o_byte_count  = r_cnt;
    assign o_last        = r_last;
    assign o_frame_ready = r_ready;
    assign o_overflow    = r_ovf;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the overlapping frame ring buffer core.
`timescale 1ns / 1ps

module testbench;
    import ofrb_pkg::*;

    localparam int unsigned STORE_BYTES  = 65536;
    localparam int unsigned FRAME_CAP    = 512;
    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 44;
    localparam int          REPORT_CAP    = 40;

    // Request and register codes that the package leaves unnamed.
    localparam t_req     REQ_UNUSED = 2'd3;
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct {
        t_kind       kind;
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        last;
        logic        ready;
        logic        ovf;
    } t_frame_result;

    // One step of the directed script: a request or a register write.
    typedef struct {
        bit            is_cfg;
        logic [1:0]    code;
        logic [16:0]   value;
        bit            typed;
        t_frame_result want;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req_type = REQ_WRITE;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_FRAME_LEN;
    logic [16:0] i_cfg_data = 17'd0;
    logic        o_strobe;
    t_kind       o_result_kind;
    logic [63:0] o_data_word;
    logic [3:0]  o_byte_count;
    logic        o_last;
    logic        o_frame_ready;
    logic        o_overflow;

    overlapping_frame_ring_buffer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_data_word   (o_data_word),
        .o_byte_count  (o_byte_count),
        .o_last        (o_last),
        .o_frame_ready (o_frame_ready),
        .o_overflow    (o_overflow)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the ring: store, pointers, fill count and registers.
    logic [7:0]  mirror_store [0:STORE_BYTES-1];
    bit          mirror_written [0:STORE_BYTES-1];
    logic [15:0] wr_ptr = 16'd0;
    logic [15:0] rd_ptr = 16'd0;
    logic [16:0] fill_cnt = 17'd0;
    logic [9:0]  cfg_frame = FRAME_LEN_RST;
    logic [9:0]  cfg_hop = HOP_RST;
    logic [16:0] cfg_ready = READY_RST;

    t_frame_result due_results [$];
    t_frame_result want;
    t_script_row   script [$];

    int  cycle_cnt = 0;
    int  fail_cnt = 0;
    int  idle_pct = 0;
    bit  cfg_open = 1'b0;
    int  n_sent = 0;
    int  n_words = 0;
    int  n_underrun = 0;
    int  n_overflow = 0;
    int  n_cleared = 0;
    int  n_settings = 0;

    function automatic t_frame_result blank_result(input t_kind kind);
        t_frame_result r;
        r.kind  = kind;
        r.word  = 64'd0;
        r.cnt   = 4'd0;
        r.last  = 1'b1;
        r.ready = 1'b0;
        r.ovf   = 1'b0;
        return r;
    endfunction

    function automatic t_script_row make_row(input bit is_cfg, input logic [1:0] code,
                                             input logic [16:0] value, input bit typed,
                                             input t_kind kind, input logic ready,
                                             input logic ovf);
        t_script_row row;
        row.is_cfg     = is_cfg;
        row.code       = code;
        row.value      = value;
        row.typed      = typed;
        row.want       = blank_result(kind);
        row.want.ready = ready;
        row.want.ovf   = ovf;
        return row;
    endfunction

    // Frame length after clamping zero up and oversize down.
    function automatic int frame_bytes();
        if (cfg_frame == 10'd0)
            return 1;
        if (cfg_frame > 10'(FRAME_CAP))
            return int'(FRAME_CAP);
        return int'(cfg_frame);
    endfunction

    // True when the next read would deliver a frame that covers a never-written byte.
    function automatic bit read_touches_blank();
        int          len;
        logic [15:0] pos;
        len = frame_bytes();
        pos = rd_ptr;
        if (int'(fill_cnt) < len)
            return 1'b0;
        for (int k = 0; k < len; k++) begin
            if (!mirror_written[pos])
                return 1'b1;
            pos = pos + 16'd1;
        end
        return 1'b0;
    endfunction

    // Advance the mirror by one accepted request and queue the results it causes.
    task automatic predict_ring_results(input t_req req, input logic [7:0] data);
        t_frame_result res;
        t_frame_result burst [$];
        int            len;
        logic [15:0]   pos;
        case (req)
            REQ_WRITE: begin
                mirror_store[wr_ptr]   = data;
                mirror_written[wr_ptr] = 1'b1;
                wr_ptr = wr_ptr + 16'd1;
                res = blank_result(KIND_WRITE_DONE);
                // Full store: overwrite the oldest byte, hold the count, flag it.
                if (fill_cnt == 17'(STORE_BYTES))
                    res.ovf = 1'b1;
                else
                    fill_cnt = fill_cnt + 17'd1;
                res.ready = (fill_cnt >= cfg_ready);
                due_results.push_back(res);
            end
            REQ_READ: begin
                len = frame_bytes();
                if (int'(fill_cnt) < len) begin
                    res = blank_result(KIND_UNDERRUN);
                    res.ready = (fill_cnt >= cfg_ready);
                    due_results.push_back(res);
                end else begin
                    pos = rd_ptr;
                    for (int k = 0; k < len; k++) begin
                        if (k % 8 == 0) begin
                            res = blank_result(KIND_FRAME_WORD);
                            res.last = 1'b0;
                        end
                        res.word[8 * (k % 8) +: 8] = mirror_store[pos];
                        res.cnt = res.cnt + 4'd1;
                        pos = pos + 16'd1;
                        if (k % 8 == 7 || k == len - 1)
                            burst.push_back(res);
                    end
                    // Hop past the count floors it at zero; the pointer still moves.
                    rd_ptr   = rd_ptr + 16'(cfg_hop);
                    fill_cnt = (17'(cfg_hop) > fill_cnt) ? 17'd0 : fill_cnt - 17'(cfg_hop);
                    burst[burst.size() - 1].last = 1'b1;
                    for (int k = 0; k < burst.size(); k++) begin
                        burst[k].ready = (fill_cnt >= cfg_ready);
                        due_results.push_back(burst[k]);
                    end
                end
            end
            REQ_CLEAR: begin
                wr_ptr   = 16'd0;
                rd_ptr   = 16'd0;
                fill_cnt = 17'd0;
                res = blank_result(KIND_CLEARED);
                res.ready = (fill_cnt >= cfg_ready);
                due_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Drop start and let the block drain before any register write.
    task automatic settle_block();
        if (!cfg_open) begin
            start <= 1'b0;
            while (due_results.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            cfg_open = 1'b1;
        end
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [16:0] val);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_FRAME_LEN: cfg_frame = val[9:0];
            CFG_HOP:       cfg_hop   = val[9:0];
            CFG_READY:     cfg_ready = val;
            default: ;
        endcase
    endtask

    // Offer one request after a random gap and hold it until the block takes it.
    task automatic send_item(input t_req req, input logic [7:0] data);
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= data;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        n_sent++;
        predict_ring_results(req, data);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_CAP)
                $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
        end
    endtask

    // Compare every strobed result with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_CAP)
                    $display("%0t: no result expected, got kind %0d word %0h",
                             $time, o_result_kind, o_data_word);
            end else begin
                want = due_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(o_result_kind));
                check_field("data_word", want.word, o_data_word);
                check_field("byte_count", 64'(want.cnt), 64'(o_byte_count));
                check_field("last", 64'(want.last), 64'(o_last));
                check_field("frame_ready", 64'(want.ready), 64'(o_frame_ready));
                check_field("overflow", 64'(want.ovf), 64'(o_overflow));
                if (want.kind == KIND_FRAME_WORD) n_words++;
                if (want.kind == KIND_UNDERRUN) n_underrun++;
                if (want.kind == KIND_CLEARED) n_cleared++;
                if (want.ovf) n_overflow++;
            end
        end
    end

    always @(posedge i_clk)
        cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("overlapping_frame_ring_buffer_core: mismatch");
        $finish;
    end

    initial begin
        int          counted;
        int          pick;
        t_req        req;
        logic [9:0]  frame_val;
        logic [9:0]  hop_val;
        logic [16:0] ready_val;
        logic [6:0]  junk_hi;

        // Directed script: reset defaults, clamps, zero hop and threshold,
        // hop past the count, the ignored request code and register extremes.
        script.push_back(make_row(1'b0, REQ_READ,  17'h000, 1'b1, KIND_UNDERRUN,   1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_WRITE, 17'h000, 1'b1, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_WRITE, 17'h0FF, 1'b1, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_UNUSED, 17'h0C3, 1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_CLEAR, 17'h03C, 1'b1, KIND_CLEARED,    1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_READY, 17'd0,   1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_FRAME_LEN, 17'd0, 1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_HOP,   17'd0,   1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_WRITE, 17'h05A, 1'b1, KIND_WRITE_DONE, 1'b1, 1'b0));
        script.push_back(make_row(1'b0, REQ_READ,  17'h000, 1'b0, KIND_FRAME_WORD, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_READ,  17'h0FF, 1'b0, KIND_FRAME_WORD, 1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_FRAME_LEN, 17'd1023, 1'b0, KIND_WRITE_DONE,
                                  1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_READ,  17'h000, 1'b1, KIND_UNDERRUN,   1'b1, 1'b0));
        script.push_back(make_row(1'b0, REQ_WRITE, 17'h000, 1'b1, KIND_WRITE_DONE, 1'b1, 1'b0));
        script.push_back(make_row(1'b0, REQ_WRITE, 17'h0FF, 1'b1, KIND_WRITE_DONE, 1'b1, 1'b0));
        script.push_back(make_row(1'b1, CFG_FRAME_LEN, 17'd3, 1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_HOP,   17'd1023, 1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_READ,  17'h000, 1'b0, KIND_FRAME_WORD, 1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_READY, 17'h10000, 1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_WRITE, 17'h081, 1'b1, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_READ,  17'h000, 1'b1, KIND_UNDERRUN,   1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_READY, 17'h1FFFF, 1'b0, KIND_WRITE_DONE, 1'b0, 1'b0));
        script.push_back(make_row(1'b1, CFG_UNUSED, 17'h1FFFF, 1'b0, KIND_WRITE_DONE,
                                  1'b0, 1'b0));
        script.push_back(make_row(1'b0, REQ_CLEAR, 17'h0FF, 1'b1, KIND_CLEARED,    1'b0, 1'b0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < script.size(); r++) begin
            if (script[r].is_cfg) begin
                cfg_write(script[r].code, script[r].value);
            end else begin
                send_item(script[r].code, script[r].value[7:0]);
                // Rows with a typed expectation replace the mirror's single result.
                if (script[r].typed)
                    due_results[due_results.size() - 1] = script[r].want;
            end
        end

        // Fill the whole store past full so the count saturates and overflow shows,
        // with the threshold at the store size so frame_ready rises on the last free byte.
        idle_pct = 0;
        cfg_write(CFG_FRAME_LEN, 17'd512);
        cfg_write(CFG_HOP, 17'd1023);
        cfg_write(CFG_READY, 17'h10000);
        send_item(REQ_CLEAR, 8'($urandom));
        repeat (STORE_BYTES + 3) send_item(REQ_WRITE, 8'($urandom));

        // Walk the read pointer to the top of the store, refill, and read a frame
        // that wraps from the last byte back to the first.
        repeat (64) send_item(REQ_READ, 8'($urandom));
        repeat (600) send_item(REQ_WRITE, 8'($urandom));
        send_item(REQ_READ, 8'($urandom));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 86;
                default: idle_pct = 6;
            endcase

            case ($urandom_range(5))
                0:       frame_val = 10'd0;
                1:       frame_val = 10'd512;
                2:       frame_val = 10'd1023;
                default: frame_val = 10'($urandom_range(40, 1));
            endcase
            case ($urandom_range(4))
                0:       hop_val = 10'd0;
                1:       hop_val = 10'd1023;
                2:       hop_val = 10'($urandom_range(1023));
                default: hop_val = 10'($urandom_range(48, 1));
            endcase
            case ($urandom_range(5))
                0:       ready_val = 17'd0;
                1:       ready_val = 17'd1;
                2:       ready_val = 17'h10000;
                3:       ready_val = 17'h1FFFF;
                4:       ready_val = fill_cnt + 17'($urandom_range(16));
                default: ready_val = 17'($urandom);
            endcase
            // Upper data bits are don't-care for the 10-bit registers; toggle them anyway.
            junk_hi = 7'($urandom);
            cfg_write(CFG_FRAME_LEN, {junk_hi, frame_val});
            junk_hi = 7'($urandom);
            cfg_write(CFG_HOP, {junk_hi, hop_val});
            cfg_write(CFG_READY, ready_val);
            n_settings++;

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    req = REQ_CLEAR;
                else if (pick < 6)
                    req = REQ_UNUSED;
                else if (pick < 40)
                    req = REQ_READ;
                else
                    req = REQ_WRITE;
                // Never read bytes that have not been written since reset.
                if (req == REQ_READ && read_touches_blank())
                    req = REQ_WRITE;
                send_item(req, 8'($urandom));
                if (req != REQ_UNUSED)
                    counted++;
            end
        end

        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d requests, %0d frame words, %0d underruns, %0d overflow writes",
                 n_sent, n_words, n_underrun, n_overflow);
        $display("run: %0d clears, %0d random register settings plus directed extremes",
                 n_cleared, n_settings);
        if (fail_cnt == 0)
            $display("overlapping_frame_ring_buffer_core: match");
        else
            $display("overlapping_frame_ring_buffer_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hdl/ofrb_pkg.sv
hdl/ofrb_store.sv
hdl/ofrb_align.sv
hdl/overlapping_frame_ring_buffer_core.sv
tb/sv/testbench.sv
